// ----- rtl/core/mlo_pkg.sv -----
// Shared widths, register indexes and types for the mip level offset/size block.
package mlo_pkg;

  localparam int IMG_W     = 3;
  localparam int LVL_W     = 4;
  localparam int TAG_W     = LVL_W + 1;
  localparam int BASE_W    = 15;
  localparam int TEXEL_W   = 5;
  localparam int SIZE_W    = 32;
  localparam int OFFSET_W  = 35;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;

  // Levels 0..15 must all be sized; the row/product/sum skew adds two cells.
  localparam int NUM_CELLS = (1 << LVL_W) + 2;

  localparam int MAX_LEVELS = 15;
  localparam logic [TAG_W-1:0] MAX_LVL_TAG = TAG_W'(MAX_LEVELS);

  localparam logic [SIZE_W-1:0] SIZE_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXEL_BYTES = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COMPR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SMALL_BLKS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_BYTES = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COUNT = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_COUNT = 3'd7;

  typedef struct packed {
    logic                   block_compressed;
    logic                   small_blocks;
    logic [TEXEL_W-1:0]     texel_bytes;
  } mlo_mode_t;

endpackage

// ----- rtl/core/mlo_if.sv -----
// Valid/ready channel interfaces for query items and result items.
interface mlo_in_if import mlo_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IMG_W-1:0] image_index;
  logic [LVL_W-1:0] mip_level;

  modport source(output valid, image_index, mip_level, input ready);
  modport sink(input valid, image_index, mip_level, output ready);
endinterface

interface mlo_out_if import mlo_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                in_range;
  logic [OFFSET_W-1:0] byte_offset;
  logic [SIZE_W-1:0]   level_bytes;

  modport source(output valid, in_range, byte_offset, level_bytes, input ready);
  modport sink(input valid, in_range, byte_offset, level_bytes, output ready);
endinterface

// ----- rtl/core/mlo_cell.sv -----
// One level cell: row size of level n, product of level n-1, sum of level n-2.
module mlo_cell import mlo_pkg::*; #(
  parameter int DIM_BITS = 14
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  mlo_mode_t              mode,
  input  logic                   vld_i,
  input  logic [IMG_W-1:0]       img_i,
  input  logic [LVL_W-1:0]       lvl_i,
  input  logic [DIM_BITS:0]      w_i,
  input  logic [DIM_BITS:0]      h_i,
  input  logic [DIM_BITS+5:0]    row_i,
  input  logic [DIM_BITS:0]      rows_i,
  input  logic                   rv_i,
  input  logic [2*DIM_BITS+6:0]  p_i,
  input  logic                   pv_i,
  input  logic [TAG_W-1:0]       pk_i,
  input  logic [2*DIM_BITS+10:0] offs_i,
  input  logic [SIZE_W-1:0]      size_i,
  output logic                   vld_o,
  output logic [IMG_W-1:0]       img_o,
  output logic [LVL_W-1:0]       lvl_o,
  output logic [DIM_BITS:0]      w_o,
  output logic [DIM_BITS:0]      h_o,
  output logic [DIM_BITS+5:0]    row_o,
  output logic [DIM_BITS:0]      rows_o,
  output logic                   rv_o,
  output logic [2*DIM_BITS+6:0]  p_o,
  output logic                   pv_o,
  output logic [TAG_W-1:0]       pk_o,
  output logic [2*DIM_BITS+10:0] offs_o,
  output logic [SIZE_W-1:0]      size_o
);

  localparam int DW = DIM_BITS + 1;
  localparam int RW = DIM_BITS + 6;
  localparam int PW = RW + DW;
  localparam int OW = PW + 4;
  localparam int SW = (PW > SIZE_W) ? PW : SIZE_W;

  logic              vld_r;
  logic [IMG_W-1:0]  img_r;
  logic [LVL_W-1:0]  lvl_r;
  logic [DW-1:0]     w_r, w_nxt;
  logic [DW-1:0]     h_r, h_nxt;
  logic [RW-1:0]     row_r, row_nxt;
  logic [DW-1:0]     rows_r, rows_nxt;
  logic              rv_r;
  logic [PW-1:0]     p_r, p_nxt;
  logic              pv_r;
  logic [TAG_W-1:0]  pk_r, pk_nxt;
  logic [OW-1:0]     offs_r, offs_nxt;
  logic [SIZE_W-1:0] size_r, size_nxt;

  logic [RW-1:0]     wt;
  logic [DW:0]       w3, h3;
  logic [SW-1:0]     p_ext;
  logic [SIZE_W-1:0] p_sat;

  always_comb begin
    wt = RW'(w_i) * RW'(mode.texel_bytes);
    w3 = {1'b0, w_i} + (DW+1)'(3);
    h3 = {1'b0, h_i} + (DW+1)'(3);
    if (mode.block_compressed) begin
      // ceil(w/4) blocks per block row, 8 or 16 bytes each
      row_nxt  = mode.small_blocks ? (RW'(w3[DW:2]) << 3) : (RW'(w3[DW:2]) << 4);
      rows_nxt = DW'(h3[DW:2]);
    end else begin
      row_nxt  = (wt + RW'(3)) & ~RW'(3);
      rows_nxt = h_i;
    end
    w_nxt = ((w_i >> 1) == '0) ? DW'(1) : (w_i >> 1);
    h_nxt = ((h_i >> 1) == '0) ? DW'(1) : (h_i >> 1);
  end

  always_comb begin
    p_nxt = PW'(row_i) * PW'(rows_i);
    pk_nxt = pv_i ? (pk_i + TAG_W'(1)) : '0;
    p_ext = SW'(p_i);
    p_sat = (p_ext > SW'(SIZE_MAX)) ? SIZE_MAX : p_ext[SIZE_W-1:0];
    offs_nxt = offs_i;
    size_nxt = size_i;
    if (pv_i) begin
      if (pk_i < TAG_W'(lvl_i)) begin
        offs_nxt = offs_i + OW'(p_i);
      end
      if (pk_i == TAG_W'(lvl_i)) begin
        size_nxt = p_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      img_r  <= img_i;
      lvl_r  <= lvl_i;
      w_r    <= w_nxt;
      h_r    <= h_nxt;
      row_r  <= row_nxt;
      rows_r <= rows_nxt;
      rv_r   <= 1'b1;
      p_r    <= p_nxt;
      pv_r   <= rv_i;
      pk_r   <= pk_nxt;
      offs_r <= offs_nxt;
      size_r <= size_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign img_o  = img_r;
  assign lvl_o  = lvl_r;
  assign w_o    = w_r;
  assign h_o    = h_r;
  assign row_o  = row_r;
  assign rows_o = rows_r;
  assign rv_o   = rv_r;
  assign p_o    = p_r;
  assign pv_o   = pv_r;
  assign pk_o   = pk_r;
  assign offs_o = offs_r;
  assign size_o = size_r;

endmodule

// ----- rtl/core/mlo_tail.sv -----
// Image base multiply, range checks and the result output register.
module mlo_tail import mlo_pkg::*; #(
  parameter int DIM_BITS = 14
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   vld_i,
  input  logic [IMG_W-1:0]       img_i,
  input  logic [LVL_W-1:0]       lvl_i,
  input  logic [2*DIM_BITS+10:0] offs_i,
  input  logic [SIZE_W-1:0]      size_i,
  input  logic [SIZE_W-1:0]      image_bytes,
  input  logic [IMG_W-1:0]       image_count,
  input  logic [LVL_W-1:0]       level_count,
  output logic                   take_o,
  mlo_out_if.source              out_ch
);

  localparam int OW   = 2 * DIM_BITS + 11;
  localparam int CW   = (OW > SIZE_W) ? OW : SIZE_W;
  localparam int SUMW = (OW > OFFSET_W) ? OW : OFFSET_W;

  logic                f1_vld_r;
  logic [OFFSET_W-1:0] mul_r, mul_nxt;
  logic [OW-1:0]       offs_r;
  logic                ok_r, ok_nxt;
  logic [SIZE_W-1:0]   size_r;

  logic                out_vld_r;
  logic                in_range_r;
  logic [OFFSET_W-1:0] byte_offset_r, byte_offset_nxt;
  logic [SIZE_W-1:0]   level_bytes_r;

  logic                out_take;
  logic [SUMW-1:0]     sum;

  always_comb begin
    mul_nxt = OFFSET_W'(img_i) * OFFSET_W'(image_bytes);
    // level zero is never rejected for its offset
    ok_nxt = (img_i < image_count) && (lvl_i < level_count) &&
             (TAG_W'(lvl_i) < MAX_LVL_TAG) &&
             ((lvl_i == '0) || (CW'(offs_i) < CW'(image_bytes)));
  end

  always_comb begin
    sum = SUMW'(mul_r) + SUMW'(offs_r);
    byte_offset_nxt = ok_r ? sum[OFFSET_W-1:0] : '0;
  end

  assign out_take = !out_vld_r || out_ch.ready;
  assign take_o   = !f1_vld_r || out_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (take_o) begin
        f1_vld_r <= vld_i;
      end
      if (out_take) begin
        out_vld_r <= f1_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_o) begin
      mul_r  <= mul_nxt;
      offs_r <= offs_i;
      ok_r   <= ok_nxt;
      size_r <= size_i;
    end
    if (out_take) begin
      in_range_r    <= ok_r;
      byte_offset_r <= byte_offset_nxt;
      level_bytes_r <= size_r;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.in_range    = in_range_r;
  assign out_ch.byte_offset = byte_offset_r;
  assign out_ch.level_bytes = level_bytes_r;

endmodule

// ----- rtl/core/mip_level_offset_and_size.sv -----
// Top level: mip level byte offset and byte size lookup for a texture store.
// Usage:
//   in_ch carries one query item (image_index, mip_level); out_ch returns one
//   result item (in_range, byte_offset, level_bytes) for each query, in order.
//   Registers are written through cfg_we/cfg_index/cfg_wdata while no query
//   is in flight; a write lands at the clock edge where cfg_we is high.
// Timing:
//   A query walks a row of 18 level cells, one cell per cycle while the row is
//   not held, then a range check/multiply stage and the output register. One
//   query is in the cell row at a time and ready returns as it leaves the row,
//   so a new query is taken only once the last one has left the row; the row
//   length sets how soon that is.
// Stall:
//   A finished result waits in the output register while out_ch.ready is low;
//   one more result can wait in the stage behind it, and then the cell row
//   holds. The next query is still taken while results wait.
// Reset:
//   rst_n (synchronous, active low) empties the cell row and the output side
//   and loads the register defaults (1x1 base, 4-byte texels, plain rows,
//   one image, one level, image size 0).
module mip_level_offset_and_size import mlo_pkg::*; #(
  parameter int DIM_BITS = 14
) (
  input  logic                 clk,
  input  logic                 rst_n,
  mlo_in_if.sink               in_ch,
  mlo_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int DW  = DIM_BITS + 1;
  localparam int RW  = DIM_BITS + 6;
  localparam int PW  = RW + DW;
  localparam int OW  = PW + 4;
  localparam int CLW = (DW > BASE_W) ? DW : BASE_W;

  // configuration registers
  logic [BASE_W-1:0]  base_width_r;
  logic [BASE_W-1:0]  base_height_r;
  logic [TEXEL_W-1:0] texel_bytes_r;
  logic               block_compressed_r;
  logic               small_blocks_r;
  logic [SIZE_W-1:0]  image_bytes_r;
  logic [IMG_W-1:0]   image_count_r;
  logic [LVL_W-1:0]   level_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_width_r       <= BASE_W'(1);
      base_height_r      <= BASE_W'(1);
      texel_bytes_r      <= TEXEL_W'(4);
      block_compressed_r <= 1'b0;
      small_blocks_r     <= 1'b1;
      image_bytes_r      <= '0;
      image_count_r      <= IMG_W'(1);
      level_count_r      <= LVL_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BASE_WIDTH:  base_width_r       <= cfg_wdata[BASE_W-1:0];
        CFG_BASE_HEIGHT: base_height_r      <= cfg_wdata[BASE_W-1:0];
        CFG_TEXEL_BYTES: texel_bytes_r      <= cfg_wdata[TEXEL_W-1:0];
        CFG_BLOCK_COMPR: block_compressed_r <= cfg_wdata[0];
        CFG_SMALL_BLKS:  small_blocks_r     <= cfg_wdata[0];
        CFG_IMAGE_BYTES: image_bytes_r      <= cfg_wdata[SIZE_W-1:0];
        CFG_IMAGE_COUNT: image_count_r      <= cfg_wdata[IMG_W-1:0];
        CFG_LEVEL_COUNT: level_count_r      <= cfg_wdata[LVL_W-1:0];
        default: ;
      endcase
    end
  end

  mlo_mode_t mode;
  assign mode = '{block_compressed: block_compressed_r,
                  small_blocks:     small_blocks_r,
                  texel_bytes:      texel_bytes_r};

  // level zero dimensions: zero reads as one, oversize clamps to 2^DIM_BITS
  logic [CLW-1:0] bw_ext, bh_ext, dim_lim;
  logic [DW-1:0]  w0, h0;

  always_comb begin
    dim_lim = CLW'(1) << DIM_BITS;
    bw_ext  = CLW'(base_width_r);
    bh_ext  = CLW'(base_height_r);
    if (bw_ext == '0) begin
      w0 = DW'(1);
    end else if (bw_ext > dim_lim) begin
      w0 = DW'(dim_lim);
    end else begin
      w0 = DW'(bw_ext);
    end
    if (bh_ext == '0) begin
      h0 = DW'(1);
    end else if (bh_ext > dim_lim) begin
      h0 = DW'(dim_lim);
    end else begin
      h0 = DW'(bh_ext);
    end
  end

  // cell row; index 0 is the entry, index k+1 the output of cell k
  logic              vld_c  [NUM_CELLS+1];
  logic [IMG_W-1:0]  img_c  [NUM_CELLS+1];
  logic [LVL_W-1:0]  lvl_c  [NUM_CELLS+1];
  logic [DW-1:0]     w_c    [NUM_CELLS+1];
  logic [DW-1:0]     h_c    [NUM_CELLS+1];
  logic [RW-1:0]     row_c  [NUM_CELLS+1];
  logic [DW-1:0]     rows_c [NUM_CELLS+1];
  logic              rv_c   [NUM_CELLS+1];
  logic [PW-1:0]     p_c    [NUM_CELLS+1];
  logic              pv_c   [NUM_CELLS+1];
  logic [TAG_W-1:0]  pk_c   [NUM_CELLS+1];
  logic [OW-1:0]     offs_c [NUM_CELLS+1];
  logic [SIZE_W-1:0] size_c [NUM_CELLS+1];

  logic busy_r;
  logic accept;
  logic adv;
  logic tail_take;
  logic [NUM_CELLS-1:0] vld_vec;

  assign in_ch.ready = !busy_r;
  assign accept      = in_ch.valid && in_ch.ready;
  assign adv         = !vld_c[NUM_CELLS] || tail_take;

  assign vld_c[0]  = accept;
  assign img_c[0]  = in_ch.image_index;
  assign lvl_c[0]  = in_ch.mip_level;
  assign w_c[0]    = w0;
  assign h_c[0]    = h0;
  assign row_c[0]  = '0;
  assign rows_c[0] = '0;
  assign rv_c[0]   = 1'b0;
  assign p_c[0]    = '0;
  assign pv_c[0]   = 1'b0;
  assign pk_c[0]   = '0;
  assign offs_c[0] = '0;
  assign size_c[0] = '0;

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    mlo_cell #(.DIM_BITS(DIM_BITS)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (adv),
      .mode   (mode),
      .vld_i  (vld_c[k]),
      .img_i  (img_c[k]),
      .lvl_i  (lvl_c[k]),
      .w_i    (w_c[k]),
      .h_i    (h_c[k]),
      .row_i  (row_c[k]),
      .rows_i (rows_c[k]),
      .rv_i   (rv_c[k]),
      .p_i    (p_c[k]),
      .pv_i   (pv_c[k]),
      .pk_i   (pk_c[k]),
      .offs_i (offs_c[k]),
      .size_i (size_c[k]),
      .vld_o  (vld_c[k+1]),
      .img_o  (img_c[k+1]),
      .lvl_o  (lvl_c[k+1]),
      .w_o    (w_c[k+1]),
      .h_o    (h_c[k+1]),
      .row_o  (row_c[k+1]),
      .rows_o (rows_c[k+1]),
      .rv_o   (rv_c[k+1]),
      .p_o    (p_c[k+1]),
      .pv_o   (pv_c[k+1]),
      .pk_o   (pk_c[k+1]),
      .offs_o (offs_c[k+1]),
      .size_o (size_c[k+1])
    );
    assign vld_vec[k] = vld_c[k+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (accept) begin
      busy_r <= 1'b1;
    end else if (vld_c[NUM_CELLS] && adv) begin
      busy_r <= 1'b0;
    end
  end

  mlo_tail #(.DIM_BITS(DIM_BITS)) u_tail (
    .clk         (clk),
    .rst_n       (rst_n),
    .vld_i       (vld_c[NUM_CELLS]),
    .img_i       (img_c[NUM_CELLS]),
    .lvl_i       (lvl_c[NUM_CELLS]),
    .offs_i      (offs_c[NUM_CELLS]),
    .size_i      (size_c[NUM_CELLS]),
    .image_bytes (image_bytes_r),
    .image_count (image_count_r),
    .level_count (level_count_r),
    .take_o      (tail_take),
    .out_ch      (out_ch)
  );

  // busy flag tracks the single item in the cell row
  a_busy_matches_row: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r == (|vld_vec))
    else $error("busy flag disagrees with cell row occupancy");

  a_one_item_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(vld_vec))
    else $error("more than one item in the cell row");

  a_accept_blocks_next: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ch.ready && vld_vec[0])
    else $error("accepted item did not enter the first cell");

endmodule
